// ===== sv/matrix_inverse_4x4_unit_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef MATRIX_INVERSE_4X4_UNIT_MACROS_SVH
`define MATRIX_INVERSE_4X4_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MI4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mi4 check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MI4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mi4 check failed");

`endif

// ===== sv/mi4_pkg.sv =====
// Shared widths, constants, state types and index tables for the 4x4 inverse.
package mi4_pkg;

    localparam int DATA_W            = 32;
    localparam int EPS_W             = 31;
    localparam int WIDE_W            = 64;
    localparam int PROD_W            = 128;
    localparam int IDX_W             = 2;
    localparam int ADDR_W            = 4;
    localparam int MAT_DEPTH         = 16;
    localparam int MINOR_COUNT       = 12;
    localparam int MINOR_AW          = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int RECIP_BITS        = 62;

    localparam logic [WIDE_W-1:0] TERM_LIMIT = 64'h1000_0000_0000_0000;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 31'd1;
    localparam logic [DATA_W-1:0] POS_LIMIT  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT  = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CAP_B,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_SAT,
        ST_ACC,
        ST_WRAP,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT_START,
        ST_OUT_WAIT,
        ST_OUT_SAT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_MINOR,
        PH_DET,
        PH_ADJ
    } phase_t;

    // Magnitude of a two's complement word; the most negative value maps to 2^63.
    function automatic logic [WIDE_W-1:0] mag64(input logic [WIDE_W-1:0] v);
        return v[WIDE_W-1] ? (~v + WIDE_W'(1)) : v;
    endfunction

    function automatic logic [WIDE_W-1:0] neg64(input logic [WIDE_W-1:0] v);
        return ~v + WIDE_W'(1);
    endfunction

    // Element addresses of minor k: slot 0 * slot 1 - slot 2 * slot 3.
    function automatic logic [ADDR_W-1:0] minor_elem(input logic [MINOR_AW-1:0] k,
                                                     input logic [1:0] slot);
        logic [15:0] row;
        row = 16'h0000;
        unique case (k)
            4'd0:    row = 16'h0541;
            4'd1:    row = 16'h0642;
            4'd2:    row = 16'h0743;
            4'd3:    row = 16'h1652;
            4'd4:    row = 16'h1753;
            4'd5:    row = 16'h2763;
            4'd6:    row = 16'h8DC9;
            4'd7:    row = 16'h8ECA;
            4'd8:    row = 16'h8FCB;
            4'd9:    row = 16'h9EDA;
            4'd10:   row = 16'h9FDB;
            4'd11:   row = 16'hAFEB;
            default: row = 16'h0000;
        endcase
        unique case (slot)
            2'd0:    return row[15:12];
            2'd1:    return row[11:8];
            2'd2:    return row[7:4];
            default: return row[3:0];
        endcase
    endfunction

    // Minor used by term t of adjugate row i (top pair; +6 picks the bottom pair).
    function automatic logic [MINOR_AW-1:0] minor_pick(input logic [1:0] i,
                                                       input logic [1:0] t);
        logic [11:0] row;
        row = 12'h000;
        unique case (i)
            2'd0:    row = 12'h543;
            2'd1:    row = 12'h521;
            2'd2:    row = 12'h420;
            default: row = 12'h310;
        endcase
        unique case (t)
            2'd0:    return row[11:8];
            2'd1:    return row[7:4];
            default: return row[3:0];
        endcase
    endfunction

    function automatic logic [1:0] src_row(input logic [1:0] j);
        unique case (j)
            2'd0:    return 2'd1;
            2'd1:    return 2'd0;
            2'd2:    return 2'd3;
            default: return 2'd2;
        endcase
    endfunction

endpackage

// ===== sv/mi4_if.sv =====
// Load, result and configuration channel interfaces.
interface mi4_in_if;
    logic                             valid;
    logic                             ready;
    logic [mi4_pkg::IDX_W-1:0]        row_index;
    logic [mi4_pkg::IDX_W-1:0]        col_index;
    logic signed [mi4_pkg::DATA_W-1:0] element_value;
    logic                             start_compute;

    modport source(output valid, row_index, col_index, element_value, start_compute,
                   input ready);
    modport sink(input valid, row_index, col_index, element_value, start_compute,
                 output ready);
endinterface

interface mi4_out_if;
    logic                             valid;
    logic                             ready;
    logic [mi4_pkg::IDX_W-1:0]        out_row;
    logic [mi4_pkg::IDX_W-1:0]        out_col;
    logic signed [mi4_pkg::DATA_W-1:0] out_value;
    logic                             singular;
    logic                             last_element;

    modport source(output valid, out_row, out_col, out_value, singular, last_element,
                   input ready);
    modport sink(input valid, out_row, out_col, out_value, singular, last_element,
                 output ready);
endinterface

interface mi4_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mi4_pkg::EPS_W-1:0]     data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// ===== sv/mi4_mul.sv =====
// 64x64 unsigned multiplier built from four 32x32 partial products.
module mi4_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mi4_pkg::WIDE_W-1:0]   a,
    input  logic [mi4_pkg::WIDE_W-1:0]   b,
    output logic [mi4_pkg::PROD_W-1:0]   product,
    output logic                         done
);
    import mi4_pkg::*;

    localparam int HALF_W     = WIDE_W / 2;
    localparam int PART_COUNT = 4;
    localparam int CNT_W      = $clog2(PART_COUNT + 1);

    logic [WIDE_W-1:0] a_reg, b_reg;
    logic [WIDE_W-1:0] pp_reg;
    logic [1:0]        pp_sel_reg;
    logic              pp_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [HALF_W-1:0] op_x, op_y;
    logic [PROD_W-1:0] pp_shifted;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin op_x = a_reg[HALF_W-1:0];      op_y = b_reg[HALF_W-1:0];      end
            2'd1:    begin op_x = a_reg[HALF_W-1:0];      op_y = b_reg[WIDE_W-1:HALF_W]; end
            2'd2:    begin op_x = a_reg[WIDE_W-1:HALF_W]; op_y = b_reg[HALF_W-1:0];      end
            default: begin op_x = a_reg[WIDE_W-1:HALF_W]; op_y = b_reg[WIDE_W-1:HALF_W]; end
        endcase
    end

    always_comb
    begin
        case (pp_sel_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd3:    pp_shifted = PROD_W'(pp_reg) << WIDE_W;
            default: pp_shifted = PROD_W'(pp_reg) << HALF_W;
        endcase
    end

    assign done    = busy_reg && (cnt_reg == CNT_W'(PART_COUNT)) && !pp_valid_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pp_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            pp_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != CNT_W'(PART_COUNT))
            begin
                cnt_reg      <= cnt_reg + CNT_W'(1);
                pp_valid_reg <= 1'b1;
            end
            else
            begin
                pp_valid_reg <= 1'b0;
            end
            if (done)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            if (busy_reg && (cnt_reg != CNT_W'(PART_COUNT)))
            begin
                pp_reg     <= WIDE_W'(op_x) * WIDE_W'(op_y);
                pp_sel_reg <= cnt_reg[1:0];
            end
            if (pp_valid_reg)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

endmodule

// ===== sv/mi4_recip.sv =====
// Restoring divider: floor(2^RECIP_BITS / divisor), one quotient bit per cycle.
module mi4_recip (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mi4_pkg::WIDE_W-1:0]   divisor,
    output logic [mi4_pkg::WIDE_W-1:0]   quotient,
    output logic                         done
);
    import mi4_pkg::*;

    localparam int BIT_W = $clog2(RECIP_BITS + 1);

    logic [BIT_W-1:0]  bit_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WIDE_W-1:0] rem_reg, quo_reg, d_reg;
    logic [WIDE_W-1:0] rem_sh;
    logic              fits;

    // Dividend is a single one at bit RECIP_BITS.
    assign rem_sh   = {rem_reg[WIDE_W-2:0], (bit_reg == BIT_W'(RECIP_BITS))};
    assign fits     = rem_sh >= d_reg;
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= BIT_W'(RECIP_BITS);
            end
            else if (busy_reg)
            begin
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - BIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - d_reg) : rem_sh;
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
        end
    end

endmodule

// ===== sv/matrix_inverse_4x4_unit.sv =====
// Top level of the 4x4 fixed-point matrix inverse (adjugate method).
//
// Usage:
//   load   : one beat writes element_value at (row_index, col_index) of the
//            4x4 store, one beat per cycle while idle. A beat with
//            start_compute set writes its element and then starts the inverse.
//   result : 16 beats in row-major order; last_element marks the final one,
//            singular is set on all 16 when the identity is given instead.
//   cfg    : one beat sets det_epsilon; always ready, write only while idle.
// Timing:
//   Loading is one beat per cycle while idle. A compute runs through one
//   shared 64x64 multiplier (four 32x32 partial products) and a
//   one-bit-per-cycle reciprocal divider. Twelve minors (24 products), six
//   determinant terms and 48 adjugate terms plus 16 scalings make up a
//   compute; a singular matrix skips the divider and adjugate. load.ready
//   is low after the start beat until the 16th result is loaded.
// Reset: the store reads as zeros (per-entry valid bits), det_epsilon is 1.
// Stall: the result register holds its beat until taken; the sequencer waits
//   at that point, no data is dropped.
module matrix_inverse_4x4_unit #(
    parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mi4_in_if.sink     load,
    mi4_out_if.source  result,
    mi4_cfg_if.sink    cfg
);
    import mi4_pkg::*;

    localparam int OUT_SHIFT = RECIP_BITS - FRACTION_BITS;
    localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRACTION_BITS;

    // ---------------- control state ----------------
    state_t               state_reg, state_next;
    phase_t               phase_reg;
    logic [ADDR_W-1:0]    k_reg;      // minor index / det term / output element
    logic [1:0]           sub_reg;    // product within a minor or adjugate sum
    logic                 sing_reg;
    logic [EPS_W-1:0]     eps_reg;
    logic                 res_valid_reg;

    // ---------------- memories ----------------
    logic [DATA_W-1:0]    mat_mem [MAT_DEPTH];
    logic [MAT_DEPTH-1:0] mat_valid_reg;
    logic [DATA_W-1:0]    mat_q_reg;
    logic                 mat_qv_reg;
    logic [WIDE_W-1:0]    scr_mem [MINOR_COUNT];
    logic [WIDE_W-1:0]    scr_q_reg;

    // ---------------- datapath ----------------
    logic [WIDE_W-1:0]    opa_reg, opb_reg;
    logic                 sign_reg;
    logic [WIDE_W-1:0]    term_reg;
    logic [WIDE_W-1:0]    acc_reg;
    logic [WIDE_W-1:0]    det_reg;
    logic                 out_neg_reg;
    logic [DATA_W-1:0]    res_val_reg;
    logic [IDX_W-1:0]     res_row_reg, res_col_reg;
    logic [DATA_W-1:0]    res_data_reg;
    logic                 res_sing_reg, res_last_reg;

    // ---------------- FSM outputs ----------------
    logic                 load_fire;
    logic [ADDR_W-1:0]    mat_raddr;
    logic [MINOR_AW-1:0]  scr_raddr;
    logic                 mul_start, div_start, out_load;
    logic [WIDE_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]    mul_product;
    logic                 mul_done, div_done;
    logic [WIDE_W-1:0]    inv_val;

    // adjugate indexing for element (i, j), term t
    logic [1:0]           adj_i, adj_j, adj_t, adj_col;
    logic [ADDR_W-1:0]    adj_elem;
    logic [MINOR_AW-1:0]  adj_minor;
    logic [WIDE_W-1:0]    mat_elem;
    logic                 subtract;
    logic                 singular_now;

    assign load_fire = load.valid && load.ready;
    assign cfg.ready = 1'b1;

    assign adj_i     = k_reg[3:2];
    assign adj_j     = k_reg[1:0];
    assign adj_t     = sub_reg;
    assign adj_col   = (adj_t < adj_i) ? adj_t : (adj_t + 2'd1);
    assign adj_elem  = {src_row(adj_j), adj_col};
    assign adj_minor = minor_pick(adj_i, adj_t) + ((adj_j < 2'd2) ? MINOR_AW'(6) : '0);

    // never-written entries read as zero
    assign mat_elem = mat_qv_reg ? {{(WIDE_W-DATA_W){mat_q_reg[DATA_W-1]}}, mat_q_reg} : '0;

    assign singular_now = (det_reg == '0) || (mag64(det_reg) < WIDE_W'(eps_reg));

    always_comb
    begin
        subtract = 1'b0;
        unique case (phase_reg)
            PH_MINOR: subtract = sub_reg[0];
            PH_DET:   subtract = (k_reg == 4'd1) || (k_reg == 4'd4);
            PH_ADJ:   subtract = adj_i[0] ^ adj_j[0] ^ adj_t[0];
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (load_fire && load.start_compute) state_next = ST_RD_A;
            ST_RD_A:      state_next = ST_RD_B;
            ST_RD_B:      state_next = ST_CAP_B;
            ST_CAP_B:     state_next = ST_MUL_START;
            ST_MUL_START: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:  if (mul_done) state_next = ST_SAT;
            ST_SAT:       state_next = ST_ACC;
            ST_ACC:
            begin
                unique case (phase_reg)
                    PH_MINOR: state_next = (sub_reg == 2'd1) ? ST_WRAP : ST_RD_A;
                    PH_DET:   state_next = (k_reg == 4'd5) ? ST_WRAP : ST_RD_A;
                    PH_ADJ:   state_next = (sub_reg == 2'd2) ? ST_WRAP : ST_RD_A;
                endcase
            end
            ST_WRAP:
            begin
                unique case (phase_reg)
                    PH_MINOR: state_next = ST_RD_A;
                    PH_DET:   state_next = ST_CHECK;
                    PH_ADJ:   state_next = ST_OUT_START;
                endcase
            end
            ST_CHECK:     state_next = singular_now ? ST_EMIT : ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_RD_A;
            ST_OUT_START: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:  if (mul_done) state_next = ST_OUT_SAT;
            ST_OUT_SAT:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (k_reg == 4'd15)
                        state_next = ST_IDLE;
                    else
                        state_next = sing_reg ? ST_EMIT : ST_RD_A;
                end
            end
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb
    begin
        load.ready = (state_reg == ST_IDLE);
        mat_raddr  = '0;
        scr_raddr  = '0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = mag64(opa_reg);
        mul_b      = mag64(opb_reg);
        out_load   = 1'b0;
        unique case (state_reg)
            ST_RD_A:
            begin
                unique case (phase_reg)
                    PH_MINOR: mat_raddr = minor_elem(k_reg, {sub_reg[0], 1'b0});
                    PH_DET:   scr_raddr = k_reg;
                    PH_ADJ:   mat_raddr = adj_elem;
                endcase
            end
            ST_RD_B:
            begin
                unique case (phase_reg)
                    PH_MINOR: mat_raddr = minor_elem(k_reg, {sub_reg[0], 1'b1});
                    PH_DET:   scr_raddr = MINOR_AW'(MINOR_COUNT - 1) - k_reg;
                    PH_ADJ:   scr_raddr = adj_minor;
                endcase
            end
            ST_MUL_START: mul_start = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_OUT_START:
            begin
                mul_start = 1'b1;
                mul_a     = mag64(acc_reg);
                mul_b     = inv_val;
            end
            ST_EMIT:      out_load = !res_valid_reg || result.ready;
            default:      ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MINOR;
            k_reg         <= '0;
            sub_reg       <= '0;
            sing_reg      <= 1'b0;
            eps_reg       <= EPS_RESET;
            res_valid_reg <= 1'b0;
            mat_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                eps_reg <= cfg.data;
            if (load_fire)
                mat_valid_reg[{load.row_index, load.col_index}] <= 1'b1;
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    phase_reg <= PH_MINOR;
                    k_reg     <= '0;
                    sub_reg   <= '0;
                end
                ST_ACC:
                begin
                    if (phase_reg == PH_DET)
                    begin
                        if (k_reg != 4'd5)
                            k_reg <= k_reg + 4'd1;
                    end
                    else if (state_next == ST_RD_A)
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                end
                ST_WRAP:
                begin
                    sub_reg <= '0;
                    if (phase_reg == PH_MINOR)
                    begin
                        if (k_reg == ADDR_W'(MINOR_COUNT - 1))
                        begin
                            phase_reg <= PH_DET;
                            k_reg     <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 4'd1;
                        end
                    end
                end
                ST_CHECK:
                begin
                    sing_reg <= singular_now;
                    k_reg    <= '0;
                end
                ST_DIV_WAIT:
                begin
                    phase_reg <= PH_ADJ;
                    k_reg     <= '0;
                    sub_reg   <= '0;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        k_reg   <= k_reg + 4'd1;
                        sub_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- matrix store: sync write on load, sync read ----------------
    always_ff @(posedge clk)
    begin
        if (load_fire)
            mat_mem[{load.row_index, load.col_index}] <= load.element_value;
        mat_q_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_qv_reg <= 1'b0;
        else
            mat_qv_reg <= mat_valid_reg[mat_raddr] && !(load_fire &&
                          ({load.row_index, load.col_index} == mat_raddr) && 1'b0);
    end

    // ---------------- minor scratch ----------------
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WRAP) && (phase_reg == PH_MINOR))
            scr_mem[k_reg] <= acc_reg[WIDE_W-1] ? neg64(mag64(acc_reg) >> FRACTION_BITS)
                                                : (acc_reg >> FRACTION_BITS);
        scr_q_reg <= scr_mem[scr_raddr];
    end

    // ---------------- arithmetic registers ----------------
    always_ff @(posedge clk)
    begin : datapath
        logic [PROD_W-1:0] sh_term, sh_out;
        logic [WIDE_W-1:0] q_term;
        logic [DATA_W-1:0] lim, q_out;
        sh_term = mul_product >> FRACTION_BITS;
        sh_out  = mul_product >> OUT_SHIFT;
        q_term  = (sh_term > PROD_W'(TERM_LIMIT)) ? TERM_LIMIT : sh_term[WIDE_W-1:0];
        lim     = out_neg_reg ? NEG_LIMIT : POS_LIMIT;
        q_out   = (sh_out > PROD_W'(lim)) ? lim : sh_out[DATA_W-1:0];

        unique case (state_reg)
            ST_IDLE:      acc_reg <= '0;
            ST_RD_B:      opa_reg <= (phase_reg == PH_DET) ? scr_q_reg : mat_elem;
            ST_CAP_B:     opb_reg <= (phase_reg == PH_MINOR) ? mat_elem : scr_q_reg;
            ST_MUL_START: sign_reg <= opa_reg[WIDE_W-1] ^ opb_reg[WIDE_W-1];
            ST_SAT:
            begin
                if (phase_reg == PH_MINOR)
                    term_reg <= sign_reg ? neg64(mul_product[WIDE_W-1:0])
                                         : mul_product[WIDE_W-1:0];
                else
                    term_reg <= sign_reg ? neg64(q_term) : q_term;
            end
            ST_ACC:       acc_reg <= subtract ? (acc_reg - term_reg) : (acc_reg + term_reg);
            ST_WRAP:
            begin
                if (phase_reg == PH_MINOR)
                    acc_reg <= '0;
                if (phase_reg == PH_DET)
                    det_reg <= acc_reg;
            end
            ST_DIV_WAIT:  acc_reg <= '0;
            ST_OUT_START: out_neg_reg <= acc_reg[WIDE_W-1] ^ det_reg[WIDE_W-1];
            ST_OUT_SAT:   res_val_reg <= out_neg_reg ? (~q_out + DATA_W'(1)) : q_out;
            ST_EMIT:
            begin
                if (out_load)
                begin
                    acc_reg      <= '0;
                    res_row_reg  <= adj_i;
                    res_col_reg  <= adj_j;
                    res_sing_reg <= sing_reg;
                    res_last_reg <= (k_reg == 4'd15);
                    if (sing_reg)
                        res_data_reg <= (adj_i == adj_j) ? ONE_VAL : '0;
                    else
                        res_data_reg <= res_val_reg;
                end
            end
            default: ;
        endcase
    end

    assign result.valid        = res_valid_reg;
    assign result.out_row      = res_row_reg;
    assign result.out_col      = res_col_reg;
    assign result.out_value    = res_data_reg;
    assign result.singular     = res_sing_reg;
    assign result.last_element = res_last_reg;

    // ---------------- shared units ----------------
    mi4_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product),
        .done    (mul_done)
    );

    mi4_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (mag64(det_reg)),
        .quotient (inv_val),
        .done     (div_done)
    );

endmodule

// ===== sv/mi4_checker.sv =====
// Port-level checks for the 4x4 inverse and their bind to the top level.
`include "matrix_inverse_4x4_unit_macros.svh"

module mi4_checker #(
    parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         load_valid,
    input logic                         load_ready,
    input logic                         load_start,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [mi4_pkg::IDX_W-1:0]    res_row,
    input logic [mi4_pkg::IDX_W-1:0]    res_col,
    input logic [mi4_pkg::DATA_W-1:0]   res_value,
    input logic                         res_singular,
    input logic                         res_last
);
    import mi4_pkg::*;

    localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRACTION_BITS;

    // a start beat locks out further loads; the check covers the sample after the beat
    `MI4_ASSERT_NEXT(a_start_locks, load_valid && load_ready && load_start, !load_ready)

    // last beat is always the bottom-right element
    `MI4_ASSERT_NOW(a_last_pos, res_valid && res_last,
                    (res_row == 2'd3) && (res_col == 2'd3))

    // singular results carry the identity
    `MI4_ASSERT_NOW(a_identity, res_valid && res_singular,
                    res_value == ((res_row == res_col) ? ONE_VAL : '0))

    // a stalled beat holds its value
    `MI4_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_value))

endmodule

bind matrix_inverse_4x4_unit mi4_checker #(.FRACTION_BITS(FRACTION_BITS)) u_mi4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (load.valid),
    .load_ready   (load.ready),
    .load_start   (load.start_compute),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_row      (result.out_row),
    .res_col      (result.out_col),
    .res_value    (result.out_value),
    .res_singular (result.singular),
    .res_last     (result.last_element)
);

// ===== tb/sv/mi4_inverse_checker.sv =====
// Checker: watches the load, result and cfg channels, predicts and compares inverse beats.
`timescale 1ns / 100ps

module mi4_inverse_checker #(
    parameter int FB = mi4_pkg::FRACTION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mi4_in_if    load,
    mi4_out_if   result,
    mi4_cfg_if   cfg,
    output int   mismatches,
    output int   awaited,
    output int   beats_seen
);

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        singular;
        logic        last;
    } inv_beat_t;

    inv_beat_t                  inv_queue[$];
    logic [31:0]                mat[16];
    logic [mi4_pkg::EPS_W-1:0]  eps;

    // 2x2 minors: a*b - c*d over element addresses
    int unsigned minor_addr[12][4] = '{
        '{0, 5, 4, 1},    '{0, 6, 4, 2},    '{0, 7, 4, 3},
        '{1, 6, 5, 2},    '{1, 7, 5, 3},    '{2, 7, 6, 3},
        '{8, 13, 12, 9},  '{8, 14, 12, 10}, '{8, 15, 12, 11},
        '{9, 14, 13, 10}, '{9, 15, 13, 11}, '{10, 15, 14, 11}};
    int unsigned adj_minor[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};
    int unsigned row_src[4] = '{1, 0, 3, 2};

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor(a*b >> sh) clipped to lim
    function automatic logic [63:0] mul_clip(logic [63:0] a, logic [63:0] b, int sh,
                                             logic [63:0] lim);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return (p > {64'd0, lim}) ? lim : p[63:0];
    endfunction

    function automatic longint fx_term(longint a, longint b);
        logic [63:0] q;
        q = mul_clip(abs64(a), abs64(b), FB, mi4_pkg::TERM_LIMIT);
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint elem(int unsigned i);
        return longint'($signed(mat[i & 15]));
    endfunction

    function automatic longint minor2(int unsigned k);
        longint d;
        longint q;
        d = elem(minor_addr[k][0]) * elem(minor_addr[k][1])
          - elem(minor_addr[k][2]) * elem(minor_addr[k][3]);
        q = longint'(abs64(d) >> FB);
        return d < 0 ? -q : q;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic predict_inverse();
        longint      mn[12];
        longint      det;
        longint      adj;
        longint      te;
        logic [63:0] recip;
        logic [63:0] q;
        logic [63:0] lim;
        bit          sing;
        bit          neg;
        int unsigned col;
        int unsigned midx;
        inv_beat_t   b;
        for (int k = 0; k < 12; k++)
            mn[k] = minor2(k);
        det = fx_term(mn[0], mn[11]) - fx_term(mn[1], mn[10]) + fx_term(mn[2], mn[9])
            + fx_term(mn[3], mn[8]) - fx_term(mn[4], mn[7]) + fx_term(mn[5], mn[6]);
        sing  = (det == 0) || (abs64(det) < {33'd0, eps});
        recip = sing ? 64'd0 : (64'd1 << mi4_pkg::RECIP_BITS) / abs64(det);
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                b.row      = i[1:0];
                b.col      = j[1:0];
                b.singular = sing;
                b.last     = (i == 3 && j == 3);
                if (sing)
                    b.value = (i == j) ? (32'd1 << FB) : 32'd0;
                else
                begin
                    adj = 0;
                    for (int t = 0; t < 3; t++)
                    begin
                        col  = (t < i) ? t : t + 1;
                        midx = adj_minor[i][t] + ((j < 2) ? 6 : 0);
                        te   = fx_term(elem(row_src[j] * 4 + col), mn[midx]);
                        adj += ((i + j + t) & 1) ? -te : te;
                    end
                    neg = (adj < 0) != (det < 0);
                    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    q   = mul_clip(abs64(adj), recip, mi4_pkg::RECIP_BITS - FB, lim);
                    b.value = neg ? -q[31:0] : q[31:0];
                end
                inv_queue.push_back(b);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        inv_beat_t want;
        if (!rst_n)
        begin
            foreach (mat[i]) mat[i] = '0;
            eps = mi4_pkg::EPS_RESET;
            inv_queue.delete();
            mismatches = 0;
            awaited    = 0;
            beats_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                eps = cfg.data;
            if (load.valid && load.ready)
            begin
                mat[{load.row_index, load.col_index}] = load.element_value;
                if (load.start_compute)
                    predict_inverse();
            end
            if (result.valid && result.ready)
            begin
                beats_seen++;
                if (inv_queue.size() == 0)
                    report("unexpected beat", result.out_value, 32'h0);
                else
                begin
                    want = inv_queue.pop_front();
                    if (result.out_row !== want.row)
                        report("out_row", 32'(result.out_row), 32'(want.row));
                    if (result.out_col !== want.col)
                        report("out_col", 32'(result.out_col), 32'(want.col));
                    if (result.out_value !== want.value)
                        report("out_value", result.out_value, want.value);
                    if (result.singular !== want.singular)
                        report("singular", 32'(result.singular), 32'(want.singular));
                    if (result.last_element !== want.last)
                        report("last_element", 32'(result.last_element), 32'(want.last));
                end
            end
            awaited = inv_queue.size();
        end
    end

endmodule

// ===== tb/sv/tb_matrix_inverse_4x4_unit.sv =====
// Testbench top: drives matrix loads, epsilon writes and result stalls, gives the verdict.
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4_unit;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mi4_in_if  load();
    mi4_out_if result();
    mi4_cfg_if cfg();

    int mismatches;
    int awaited;
    int beats_seen;
    int cycles = 0;
    int load_beats = 0;
    int inv_requests = 0;
    int eps_writes = 0;
    bit quiet = 1'b0;     // no idling on either side in the closing phase
    bit hold_req = 1'b0;  // asks the result side for one long stall

    always #4 clk = ~clk;

    matrix_inverse_4x4_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .result (result),
        .cfg    (cfg)
    );

    mi4_inverse_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result     (result),
        .cfg        (cfg),
        .mismatches (mismatches),
        .awaited    (awaited),
        .beats_seen (beats_seen)
    );

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d beats outstanding", awaited);
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request so the
    // load side backs up behind a full compute.
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result.ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                result.ready = 1'b1;
        end
    end

    // One load beat; valid stays high into the next beat unless a gap is drawn.
    task automatic send_beat(logic [1:0] r, logic [1:0] c, logic [31:0] v, logic go);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            load.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        load.valid         = 1'b1;
        load.row_index     = r;
        load.col_index     = c;
        load.element_value = v;
        load.start_compute = go;
        do @(posedge clk); while (!load.ready);
        load_beats++;
        if (go)
            inv_requests++;
    endtask

    // Drain the results, then let the sequencer return to idle.
    task automatic settle();
        @(negedge clk);
        load.valid = 1'b0;
        while (awaited != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_eps(logic [mi4_pkg::EPS_W-1:0] v);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.data  = v;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
        eps_writes++;
    endtask

    // Mix of small Q16.16 values, raw words, extremes, zero and +-1.0.
    function automatic logic [31:0] pick_value();
        logic [18:0] s;
        s = 19'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return {{13{s[18]}}, s};
            6:                return $urandom;
            7:                return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            8:                return 32'h0;
            default:          return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
    endfunction

    // Full matrix in shuffled order, the last element carries start.
    task automatic send_matrix();
        int unsigned ord[16];
        int unsigned k;
        int unsigned tmp;
        foreach (ord[i]) ord[i] = i;
        for (int i = 15; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            tmp = ord[i];
            ord[i] = ord[k];
            ord[k] = tmp;
        end
        for (int i = 0; i < 16; i++)
            send_beat(ord[i][3:2], ord[i][1:0], pick_value(), i == 15);
    endtask

    task automatic random_phase(int target);
        int n;
        n = 0;
        while (n < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                send_matrix();
                n += 16;
            end
            else
            begin
                // stray writes, some with start: partially updated matrices
                repeat ($urandom_range(1, 4))
                begin
                    send_beat(2'($urandom), 2'($urandom), pick_value(),
                              $urandom_range(0, 5) == 0);
                    n++;
                end
            end
        end
    endtask

    logic [mi4_pkg::EPS_W-1:0] eps_plan[6];

    initial
    begin
        load.valid         = 1'b0;
        load.row_index     = '0;
        load.col_index     = '0;
        load.element_value = '0;
        load.start_compute = 1'b0;
        cfg.valid          = 1'b0;
        cfg.data           = '0;
        repeat (4) @(posedge clk);
        rst_n = 1'b1;

        // Directed: zero store (det exactly zero), diagonal 2.0, extremes.
        send_beat(2'd0, 2'd0, 32'h0, 1'b1);
        send_beat(2'd1, 2'd1, 32'h0002_0000, 1'b0);
        send_beat(2'd2, 2'd2, 32'h0002_0000, 1'b0);
        send_beat(2'd3, 2'd3, 32'h0002_0000, 1'b0);
        send_beat(2'd0, 2'd0, 32'h0002_0000, 1'b1);
        send_beat(2'd3, 2'd0, 32'h8000_0000, 1'b0);
        send_beat(2'd0, 2'd3, 32'h7FFF_FFFF, 1'b1);
        send_beat(2'd0, 2'd0, 32'h8000_0000, 1'b0);
        send_beat(2'd1, 2'd1, 32'h8000_0000, 1'b1);
        send_beat(2'd3, 2'd3, 32'hFFFF_FFFF, 1'b0);
        send_beat(2'd2, 2'd1, 32'h0000_0001, 1'b1);
        // tiny diagonal over the extremes still in the store: determinant nonzero
        send_beat(2'd0, 2'd0, 32'h0000_0100, 1'b0);
        send_beat(2'd1, 2'd1, 32'h0000_0100, 1'b0);
        send_beat(2'd2, 2'd2, 32'h0000_0100, 1'b0);
        send_beat(2'd3, 2'd3, 32'h0000_0100, 1'b1);
        settle();

        eps_plan = '{31'd0, 31'h7FFF_FFFF, 31'h0000_0100, 31'($urandom), 31'd1, 31'h0001_0000};
        for (int p = 0; p < 6; p++)
        begin
            write_eps(eps_plan[p]);
            if (p == 0)
            begin
                // epsilon 0: a zero row still has to come out singular
                for (int c = 0; c < 4; c++)
                    send_beat(2'd2, 2'(c), 32'h0, c == 3);
            end
            if (p == 2)
                hold_req = 1'b1;
            if (p == 5)
                quiet = 1'b1;
            random_phase(65);
            settle();
        end

        repeat (50) @(negedge clk);
        $display("covered %0d load beats, %0d inverse requests, %0d result beats,",
                 load_beats, inv_requests, beats_seen);
        $display("%0d epsilon writes incl. zero and full scale, one long result stall",
                 eps_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
